FILE: hw/rtl/sil_pkg.sv
// Shared types and codes for the sorted insertion list.
// Used by sorted_insertion_list_core and its testbench; depends on nothing.
package sil_pkg;

  // Command codes of an input word
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DUMP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Result kinds of an output word
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam int KEY_W = 64;
  localparam int TAG_W = 16;

  // One stored entry, as held in the RAM
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PUT,
    ST_DUMP,
    ST_RESP
  } state_t;

endpackage

FILE: hw/rtl/sil_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package dependency.
module sil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/sorted_insertion_list_core.sv
// Sorted insertion list: entries kept in ascending key order in one RAM.
// Depends on sil_pkg and sil_ram.
//
//   channel | direction | handshake          | words
//   in_     | input     | in_valid/in_stall   | command, key, tag
//   out_    | output    | out_valid/out_stall | kind, key_res, tag_res, status, last
//
// Insert: a full list answers with drop status; an empty one takes the entry
// at once; else a scan from the tail shifts each entry not below the new key
// one place toward the tail (one RAM read and one write per cycle), then writes
// it. Dump: entries in key order, paced by the RAM read port. One command is
// worked at a time. Reset clears the entry count; the RAM needs no clearing as
// only the first count entries are read. A stalled output holds DUMP and RESP.
module sorted_insertion_list_core #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic signed [sil_pkg::KEY_W-1:0] in_key,
  input  logic [sil_pkg::TAG_W-1:0]  in_tag,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic signed [sil_pkg::KEY_W-1:0] out_key_res,
  output logic [sil_pkg::TAG_W-1:0]  out_tag_res,
  output logic                       out_status,
  output logic                       out_last
);
  import sil_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(entry_t);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  entry_t new_r, new_nxt;
  logic [1:0] resp_kind_r, resp_kind_nxt;
  logic resp_status_r, resp_status_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic signed [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic out_status_r, out_status_nxt;
  logic out_last_r, out_last_nxt;

  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t wr_data, rd_data;
  logic [EW-1:0] rd_word;
  logic [CW-1:0] cnt_m1;
  logic out_can;
  logic dump_last;

  sil_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_data   = rd_word;
  assign cnt_m1    = count_r - CW'(1);
  assign out_can   = !out_valid_r || !out_stall;
  assign dump_last = (CW'(idx_r) == cnt_m1);
  assign in_stall  = (state_r != ST_IDLE);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    new_r         <= new_nxt;
    resp_kind_r   <= resp_kind_nxt;
    resp_status_r <= resp_status_nxt;
    out_kind_r    <= out_kind_nxt;
    out_key_r     <= out_key_nxt;
    out_tag_r     <= out_tag_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Next state, RAM accesses and output loading
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    new_nxt         = new_r;
    resp_kind_nxt   = resp_kind_r;
    resp_status_nxt = resp_status_r;
    out_valid_nxt   = out_valid_r;
    out_kind_nxt    = out_kind_r;
    out_key_nxt     = out_key_r;
    out_tag_nxt     = out_tag_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = new_r;
    rd_en           = 1'b0;
    rd_addr         = '0;

    // Drop the output word once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          new_nxt.key     = in_key;
          new_nxt.tag     = in_tag;
          resp_status_nxt = 1'b0;
          unique case (in_command)
            CMD_INSERT: begin
              resp_kind_nxt = KIND_ACK;
              if (count_r == CW'(DEPTH)) begin
                resp_status_nxt = 1'b1;
                state_nxt       = ST_RESP;
              end else if (count_r == '0) begin
                count_nxt    = count_r + CW'(1);
                wr_en        = 1'b1;
                wr_data.key  = in_key;
                wr_data.tag  = in_tag;
                state_nxt    = ST_RESP;
              end else begin
                // Walk from the tail toward the head
                count_nxt = count_r + CW'(1);
                rd_en     = 1'b1;
                rd_addr   = cnt_m1[AW-1:0];
                idx_nxt   = cnt_m1[AW-1:0];
                state_nxt = ST_SCAN;
              end
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                resp_kind_nxt = KIND_EMPTY;
                state_nxt     = ST_RESP;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = ST_DUMP;
              end
            end
            CMD_CLEAR: begin
              count_nxt     = '0;
              resp_kind_nxt = KIND_CLEAR;
              state_nxt     = ST_RESP;
            end
            default: begin
              // Unused command: no result, no change
            end
          endcase
        end
      end

      ST_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = idx_r + AW'(1);
        if (rd_data.key < new_r.key) begin
          // Slot found just behind this entry
          wr_data   = new_r;
          state_nxt = ST_RESP;
        end else begin
          // Shift this entry one place toward the tail
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = ST_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end
      end

      ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_r;
        state_nxt = ST_RESP;
      end

      ST_DUMP: begin
        if (out_can) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_ENTRY;
          out_key_nxt    = rd_data.key;
          out_tag_nxt    = rd_data.tag;
          out_status_nxt = 1'b0;
          out_last_nxt   = dump_last;
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      ST_RESP: begin
        if (out_can) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = resp_kind_r;
          out_key_nxt    = '0;
          out_tag_nxt    = '0;
          out_status_nxt = resp_status_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_key_res = out_key_r;
  assign out_tag_res = out_tag_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

  // The entry count never passes the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // A dropped insert is reported only as a final insert ack
  a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_kind_r == KIND_ACK && out_last_r))
    else $error("drop status on a word other than a final insert ack");

  // A dump reads only stored entries
  a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (CW'(idx_r) < count_r))
    else $error("dump index past the stored entries");

  // A scan only runs on a list that already held entries
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (count_r > CW'(1) && CW'(idx_r) < count_r - CW'(1)))
    else $error("scan index outside the list");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for sorted_insertion_list_core: a directed table, then random words.
// Results are predicted by a shadow copy of the sorted list. Depends on sil_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
  import sil_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int RAND_ITEMS = 226;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 40;

  // Unused command code; the core ignores it
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    logic                    status;
    logic                    last;
  } out_word_t;

  // One directed stimulus row; fixed rows carry an answer typed in by hand
  typedef struct {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
    bit                      fixed;
    logic [1:0]              fkind;
    logic                    fstatus;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_command;
  logic signed [KEY_W-1:0] in_key;
  logic [TAG_W-1:0]        in_tag;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_kind;
  logic signed [KEY_W-1:0] out_key_res;
  logic [TAG_W-1:0]        out_tag_res;
  logic                    out_status;
  logic                    out_last;

  // Shadow copy of the list, kept in ascending key order
  logic signed [KEY_W-1:0] shadow_key [LIST_DEPTH];
  logic [TAG_W-1:0]        shadow_tag [LIST_DEPTH];
  int                      shadow_len;

  out_word_t step_words [$];
  out_word_t due_words [$];
  stim_row_t dir_table [$];

  int errors;
  int cycle_cnt;
  int send_mode;
  bit hold_req;

  sorted_insertion_list_core #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_key     (in_key),
    .in_tag     (in_tag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_key_res(out_key_res),
    .out_tag_res(out_tag_res),
    .out_status (out_status),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_word_t make_word(logic [1:0] kind, logic signed [KEY_W-1:0] key,
                                          logic [TAG_W-1:0] tag, logic status, logic last);
    out_word_t w;
    w.kind = kind;
    w.key = key;
    w.tag = tag;
    w.status = status;
    w.last = last;
    return w;
  endfunction

  // Apply one command to the shadow list and collect the words it should produce
  function automatic void shadow_list_apply(logic [1:0] cmd, logic signed [KEY_W-1:0] key,
                                            logic [TAG_W-1:0] tag);
    int pos;
    int i;
    step_words.delete();
    case (cmd)
      CMD_INSERT: begin
        if (shadow_len >= LIST_DEPTH) begin
          step_words.push_back(make_word(KIND_ACK, '0, '0, STATUS_FULL, 1'b1));
        end else begin
          // New key goes ahead of the first key that is not smaller
          pos = 0;
          while (pos < shadow_len && shadow_key[pos] < key) pos++;
          for (i = shadow_len; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_key[pos] = key;
          shadow_tag[pos] = tag;
          shadow_len++;
          step_words.push_back(make_word(KIND_ACK, '0, '0, STATUS_OK, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (shadow_len == 0) begin
          step_words.push_back(make_word(KIND_EMPTY, '0, '0, STATUS_OK, 1'b1));
        end else begin
          for (i = 0; i < shadow_len; i++)
            step_words.push_back(make_word(KIND_ENTRY, shadow_key[i], shadow_tag[i],
                                           STATUS_OK, i == shadow_len - 1));
        end
      end
      CMD_CLEAR: begin
        shadow_len = 0;
        step_words.push_back(make_word(KIND_CLEAR, '0, '0, STATUS_OK, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] cmd, logic signed [KEY_W-1:0] key,
                                         logic [TAG_W-1:0] tag, bit fixed,
                                         logic [1:0] fkind, logic fstatus);
    stim_row_t r;
    r.cmd = cmd;
    r.key = key;
    r.tag = tag;
    r.fixed = fixed;
    r.fkind = fkind;
    r.fstatus = fstatus;
    return r;
  endfunction

  // Idle length for one word: mode 0 never idles, mode 1 idles briefly, mode 2 idles longer
  function automatic int gap_draw(int mode);
    int gap;
    case (mode)
      0: gap = 0;
      1: gap = $urandom_range(0, 3);
      default: gap = $urandom_range(0, 18);
    endcase
    return gap;
  endfunction

  // Mix wide random keys with small ones, extremes and copies of stored keys
  function automatic logic signed [KEY_W-1:0] key_draw();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: k = KEY_W'($signed($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0: k = KEY_MIN;
          1: k = KEY_MIN + 1;
          2: k = KEY_MAX - 1;
          default: k = KEY_MAX;
        endcase
      end
      default: begin
        if (shadow_len > 0) k = shadow_key[$urandom_range(0, shadow_len - 1)];
        else k = {$urandom, $urandom};
      end
    endcase
    return k;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected results
  task automatic send_word(logic [1:0] cmd, logic signed [KEY_W-1:0] key,
                           logic [TAG_W-1:0] tag, bit fixed, logic [1:0] fkind,
                           logic fstatus);
    int gap;
    gap = gap_draw(send_mode);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    in_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow_list_apply(cmd, key, tag);
    if (fixed) due_words.push_back(make_word(fkind, '0, '0, fstatus, 1'b1));
    else foreach (step_words[i]) due_words.push_back(step_words[i]);
  endtask

  // Stop offering and let every expected result come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  // Result checker: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word kind=%0d key=%0d tag=%0h status=%0d last=%0d",
                   $time, out_kind, out_key_res, out_tag_res, out_status, out_last);
      end else begin
        exp_w = due_words.pop_front();
        if (out_kind !== exp_w.kind || out_key_res !== exp_w.key ||
            out_tag_res !== exp_w.tag || out_status !== exp_w.status ||
            out_last !== exp_w.last) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: mismatch expected kind=%0d key=%0d tag=%0h status=%0d last=%0d",
                     $time, exp_w.kind, exp_w.key, exp_w.tag, exp_w.status, exp_w.last);
            $display("%0t:          actual   kind=%0d key=%0d tag=%0h status=%0d last=%0d",
                     $time, out_kind, out_key_res, out_tag_res, out_status, out_last);
          end
        end
      end
    end
  end

  // Watchdog: end the run if it takes far longer than the slowest correct run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sorted_insertion_list_core regression: fail");
      $finish;
    end
  end

  // Receiver: random stall before each word, one long hold-off on request
  initial begin
    int n;
    int recv_mode;
    int words_seen;
    bit hold_done;
    out_stall = 1'b0;
    recv_mode = 2;
    words_seen = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (words_seen % 32 == 0) recv_mode = $urandom_range(0, 2);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = gap_draw(recv_mode);
      end
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      words_seen++;
    end
  end

  // Sender: directed table, then random words, then drain and report
  initial begin
    int item_no;
    int words_sent;
    int pick;
    logic [1:0] cmd;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_INSERT;
    in_key = '0;
    in_tag = '0;
    shadow_len = 0;
    send_mode = 2;
    hold_req = 1'b0;

    // Directed rows: empty list, ignored fields, extremes, equal keys, full list
    dir_table.push_back(stim_row(CMD_DUMP, KEY_MAX, 16'hFFFF, 1'b1, KIND_EMPTY, STATUS_OK));
    dir_table.push_back(stim_row(CMD_CLEAR, -64'sd1, 16'hAAAA, 1'b1, KIND_CLEAR, STATUS_OK));
    dir_table.push_back(stim_row(CMD_NOP, 64'sd123, 16'h0005, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sd0, 16'h0000, 1'b1, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, KEY_MAX, 16'hFFFF, 1'b1, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_DUMP, KEY_MIN, 16'h5555, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, KEY_MIN, 16'h0001, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, -64'sd1, 16'h8000, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sd0, 16'h0002, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, KEY_MAX, 16'h0003, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, KEY_MIN, 16'h0004, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sd1, 16'h7FFF, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sh5555_5555_5555_5555, 16'h1234, 1'b0,
                                 KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'shAAAA_AAAA_AAAA_AAAA, 16'hEDCB, 1'b0,
                                 KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, -64'sd2, 16'h00FF, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sd2, 16'hFF00, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sh0000_0001_0000_0000, 16'h0F0F, 1'b0,
                                 KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'shFFFF_FFFF_0000_0000, 16'hF0F0, 1'b0,
                                 KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sd0, 16'h0006, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, KEY_MAX - 1, 16'h0007, 1'b0,
                                 KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_INSERT, 64'sd42, 16'h0008, 1'b1, KIND_ACK, STATUS_FULL));
    dir_table.push_back(stim_row(CMD_DUMP, 64'sd0, 16'h0000, 1'b0, KIND_ACK, STATUS_OK));
    dir_table.push_back(stim_row(CMD_CLEAR, KEY_MIN, 16'h0000, 1'b1, KIND_CLEAR, STATUS_OK));
    dir_table.push_back(stim_row(CMD_DUMP, 64'sd7, 16'h1111, 1'b1, KIND_EMPTY, STATUS_OK));

    // Hold reset, release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i])
      send_word(dir_table[i].cmd, dir_table[i].key, dir_table[i].tag,
                dir_table[i].fixed, dir_table[i].fkind, dir_table[i].fstatus);
    wait_drained();

    // Random part: mostly inserts so the list fills, with dumps, clears and noise
    item_no = 0;
    words_sent = 0;
    while (words_sent < RAND_ITEMS) begin
      if (item_no % 32 == 0) send_mode = $urandom_range(0, 2);
      if (item_no == 60) hold_req = 1'b1;
      if (item_no == 150) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 70) cmd = CMD_INSERT;
      else if (pick < 86) cmd = CMD_DUMP;
      else if (pick < 91) cmd = CMD_CLEAR;
      else cmd = CMD_NOP;
      key = key_draw();
      tag = TAG_W'($urandom_range(0, 65535));
      send_word(cmd, key, tag, 1'b0, KIND_ACK, STATUS_OK);
      words_sent++;
      item_no++;
    end

    // Drain, then watch a few more cycles for stray words
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && due_words.size() == 0) begin
      $display("sorted_insertion_list_core regression: pass");
    end else begin
      $display("sorted_insertion_list_core regression: fail");
    end
    $finish;
  end

endmodule
